// ----- rtl/core/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and codes for the software timer bank core.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int ID_W   = 8;
    localparam int TICK_W = 32;
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_POLL   = 2'd1;
    localparam logic [1:0] OP_HALT   = 2'd2;
    localparam logic [1:0] OP_RESUME = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_PARAM    = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    typedef enum logic [2:0] {
        KIND_ARM    = 3'd0,
        KIND_POLL   = 3'd1,
        KIND_HALT   = 3'd2,
        KIND_RESUME = 3'd3,
        KIND_PARAM  = 3'd4
    } t_kind;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        t_kind               kind;
        logic [ID_W-1:0]     id;
        logic [TICK_W-1:0]   now;
        logic [TICK_W-1:0]   deadline;
        logic                wrap;
    } t_cmd;

endpackage

// ----- rtl/core/stb_front.sv -----
// ----------------------------------------------------------------------------
// stb_front
// Classifies an incoming command: parameter checks and arm deadline math.
// ----------------------------------------------------------------------------
module stb_front #(
    parameter int NUM_TIMERS = 16
) (
    input  logic [1:0]                i_opcode,
    input  logic [stb_pkg::ID_W-1:0]  i_timer_id,
    input  logic [stb_pkg::TICK_W-1:0] i_tick_count,
    input  logic                      i_time_unit,
    input  logic [stb_pkg::TICK_W-1:0] i_current_tick,
    output stb_pkg::t_cmd             o_cmd
);
    import stb_pkg::*;

    logic            id_bad;
    logic [TICK_W:0] sum;
    logic            wrap;

    assign id_bad = ({1'b0, i_timer_id} >= (ID_W+1)'(NUM_TIMERS));

    // Carry out of now + count marks a deadline past the wrap; the deadline
    // there is count - (MAX - now), i.e. the modular sum plus one.
    assign sum  = {1'b0, i_current_tick} + {1'b0, i_tick_count};
    assign wrap = sum[TICK_W];

    always_comb begin
        o_cmd.id       = i_timer_id;
        o_cmd.now      = i_current_tick;
        o_cmd.wrap     = wrap;
        o_cmd.deadline = sum[TICK_W-1:0] + TICK_W'(wrap);
        unique case (i_opcode)
            OP_ARM: begin
                o_cmd.kind = (id_bad || (i_tick_count == '0) || i_time_unit)
                             ? KIND_PARAM : KIND_ARM;
            end
            OP_POLL: begin
                o_cmd.kind = id_bad ? KIND_PARAM : KIND_POLL;
            end
            OP_HALT:   o_cmd.kind = KIND_HALT;
            OP_RESUME: o_cmd.kind = KIND_RESUME;
            default:   o_cmd.kind = KIND_PARAM;
        endcase
    end

endmodule

// ----- rtl/core/stb_queue.sv -----
// ----------------------------------------------------------------------------
// stb_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module stb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output stb_pkg::t_cmd o_data
);
    import stb_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/stb_back.sv -----
// ----------------------------------------------------------------------------
// stb_back
// Timer state and command execution: a load stage reads the timer memories,
// an execute stage updates state and fills the result register.
// ----------------------------------------------------------------------------
module stb_back #(
    parameter int NUM_TIMERS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  stb_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_res_valid,
    output logic [1:0]    o_res_status,
    input  logic          i_res_ready
);
    import stb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [TICK_W-1:0]     r_deadline_mem [NUM_TIMERS];
    logic [TICK_W-1:0]     r_start_mem    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_expired, n_expired;
    logic [NUM_TIMERS-1:0] r_wait_wrap, n_wait_wrap;
    logic                  r_configured, n_configured;
    logic                  r_enabled, n_enabled;

    logic                  r_x_valid;
    t_cmd                  r_x;
    logic [TICK_W-1:0]     r_x_deadline;
    logic [TICK_W-1:0]     r_x_start;

    logic                  r_out_valid;
    logic [1:0]            r_out_status;

    logic                  x_commit;
    logic                  x_load;
    logic                  blocked;
    logic                  arm_write;
    logic                  bypass;
    logic [IDX_W-1:0]      x_idx;
    logic [IDX_W-1:0]      q_idx;
    logic [1:0]            x_status;

    assign x_idx    = r_x.id[IDX_W-1:0];
    assign q_idx    = i_q_data.id[IDX_W-1:0];
    assign blocked  = r_configured && !r_enabled;
    assign x_commit = r_x_valid && (!r_out_valid || i_res_ready);
    assign x_load   = i_q_valid && (!r_x_valid || x_commit);
    assign o_q_pop  = x_load;
    assign arm_write = x_commit && (r_x.kind == KIND_ARM) && !blocked;
    // The memory read of the loading command misses a write on the same edge.
    assign bypass   = arm_write && (x_idx == q_idx);

    always_comb begin
        n_expired    = r_expired;
        n_wait_wrap  = r_wait_wrap;
        n_configured = r_configured;
        n_enabled    = r_enabled;
        x_status     = ST_DONE;
        unique case (r_x.kind)
            KIND_PARAM: x_status = ST_PARAM;
            KIND_HALT: begin
                n_enabled = 1'b0;
            end
            KIND_RESUME: begin
                n_enabled = 1'b1;
            end
            KIND_ARM: begin
                if (blocked) begin
                    x_status = ST_DISABLED;
                end else begin
                    n_configured       = 1'b1;
                    n_enabled          = 1'b1;
                    n_wait_wrap[x_idx] = r_x.wrap;
                    n_expired[x_idx]   = 1'b0;
                end
            end
            KIND_POLL: begin
                priority if (blocked) begin
                    x_status = ST_DISABLED;
                end else if (r_expired[x_idx]) begin
                    x_status = ST_DONE;
                end else if (r_wait_wrap[x_idx]) begin
                    x_status = ST_RUNNING;
                    if (r_x.now < r_x_start) begin
                        n_wait_wrap[x_idx] = 1'b0;
                    end
                end else if (r_x.now >= r_x_deadline) begin
                    x_status         = ST_DONE;
                    n_expired[x_idx] = 1'b1;
                end else begin
                    x_status = ST_RUNNING;
                end
            end
            default: x_status = ST_PARAM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expired    <= '1;
            r_wait_wrap  <= '0;
            r_configured <= 1'b0;
            r_enabled    <= 1'b0;
            r_x_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (x_commit) begin
                r_expired    <= n_expired;
                r_wait_wrap  <= n_wait_wrap;
                r_configured <= n_configured;
                r_enabled    <= n_enabled;
            end
            if (x_load) begin
                r_x_valid <= 1'b1;
            end else if (x_commit) begin
                r_x_valid <= 1'b0;
            end
            if (x_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Timer memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (arm_write) begin
            r_deadline_mem[x_idx] <= r_x.deadline;
            r_start_mem[x_idx]    <= r_x.now;
        end
        if (x_load) begin
            r_x <= i_q_data;
            if (bypass) begin
                r_x_deadline <= r_x.deadline;
                r_x_start    <= r_x.now;
            end else begin
                r_x_deadline <= r_deadline_mem[q_idx];
                r_x_start    <= r_start_mem[q_idx];
            end
        end
        if (x_commit) begin
            r_out_status <= x_status;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_status = r_out_status;

endmodule

// ----- rtl/core/software_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// software_timer_bank_core
// Bank of one-shot timers checked against a tick that arrives with each
// command; arm, poll, halt and resume, one status per command.
// ----------------------------------------------------------------------------
// The core takes one command per cycle while its queue has room and returns
// one status per command in order. A command is classified on entry, queued,
// read from the timer memories in a load stage and executed into the result
// register. The sustained rate of one command per cycle, held while the
// result output is not back-pressured, is set by the execute stage, which
// uses the single write and read port of the deadline and start-tick memories
// once per command; a write forwards to a command loaded on the same edge.
// No clearing pass runs after reset: never-armed timers read as expired.
module software_timer_bank_core #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // timer_id[7:0], tick_count[39:8], time_unit[40], current_tick[72:41], zero pad
    input  logic [79:0] i_s_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status_code[1:0], zero pad
    output logic [7:0]  o_m_tdata
);
    import stb_pkg::*;

    t_cmd       front_cmd;
    t_cmd       q_cmd;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic [1:0] res_status;

    stb_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .i_opcode       (i_s_tuser),
        .i_timer_id     (i_s_tdata[7:0]),
        .i_tick_count   (i_s_tdata[39:8]),
        .i_time_unit    (i_s_tdata[40]),
        .i_current_tick (i_s_tdata[72:41]),
        .o_cmd          (front_cmd)
    );

    stb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    stb_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_cmd),
        .o_q_pop      (q_pop),
        .o_res_valid  (o_m_tvalid),
        .o_res_status (res_status),
        .i_res_ready  (i_m_tready)
    );

    assign o_s_tready = !q_full;
    assign o_m_tdata  = {6'd0, res_status};

endmodule
